>>> rtl/grlr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grlr_pkg
// Shared types and constants of the gamma ramp linear resampler.
// ----------------------------------------------------------------------------
package grlr_pkg;

   localparam int CHAN_W     = 16;
   localparam int IDX_W      = 12;
   localparam int RAMP_W     = 13;
   localparam int STATUS_W   = 2;
   localparam int NUM_CHAN   = 3;
   localparam int MIX_W      = CHAN_W + RAMP_W;
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = CHAN_W * NUM_CHAN;

   localparam int MAX_POINTS_DEF = 1024;

   localparam logic [RAMP_W-1:0] RAMP_RESET = RAMP_W'(256);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [NUM_CHAN-1:0] point_type;

endpackage

>>> rtl/grlr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grlr_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grlr_div #(
   parameter int W = 22
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [W-1:0]               dividend,
   input  logic [grlr_pkg::RAMP_W-1:0] divisor,
   output logic                       done,
   output logic [W-1:0]               quotient,
   output logic [grlr_pkg::RAMP_W-1:0] remainder
);
   import grlr_pkg::*;

   localparam int CNT_W = $clog2(W + 1);

   logic [RAMP_W-1:0] rem_ff;
   logic [W-1:0]      quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [RAMP_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(W);
            rem_ff  <= '0;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
            if (fits) begin
               rem_ff <= RAMP_W'(trial - {1'b0, divisor});
            end else begin
               rem_ff <= trial[RAMP_W-1:0];
            end
            quo_ff <= {quo_ff[W-2:0], fits};
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/grlr_point_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grlr_point_mem
// Curve point store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module grlr_point_mem #(
   parameter int DEPTH = grlr_pkg::MAX_POINTS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  grlr_pkg::point_type      wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output grlr_pkg::point_type      rd_data
);
   import grlr_pkg::*;

   point_type mem_ff [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gamma_ramp_linear_resampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_ramp_linear_resampler_core
// Resamples a loaded RGB calibration curve onto a gamma ramp of ramp_size
// entries by linear interpolation, with each division truncated.
// ----------------------------------------------------------------------------
// A load word (tuser bit 0 low) stores one curve point, unless the store is
// full, and gives no result; tuser bit 1 restarts the curve. A query word
// returns one result. An error result goes straight to the output state; a
// valid query passes through bit-serial division: one divider for the ramp
// position, then three parallel ones for the channel blend. When the position
// falls exactly on a point, the blend division is skipped. req_tready rises
// together with rsp_tvalid. The point store is one memory with a single read
// port, so the two neighbor points are fetched in consecutive cycles. One
// query is worked on at a time, and a new word is taken while a result waits.
module gamma_ramp_linear_resampler_core #(
   parameter int MAX_POINTS = grlr_pkg::MAX_POINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // red_in, green_in, blue_in, entry_index, zero fill
   input  logic [grlr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd, first
   input  logic [grlr_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // red_out, green_out, blue_out
   output logic [grlr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [grlr_pkg::STATUS_W-1:0]     rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [grlr_pkg::RAMP_W-1:0]       csr_data
);
   import grlr_pkg::*;

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int NUM_W = AW + IDX_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS_START,
      ST_POS_WAIT,
      ST_RD_LO,
      ST_RD_HI,
      ST_MIX_MUL,
      ST_MIX_START,
      ST_MIX_WAIT,
      ST_OUT
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [RAMP_W-1:0]   ramp_size_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [AW-1:0]       lo_ff;
   logic [RAMP_W-1:0]   rem_ff;
   point_type           v1_ff;
   logic [MIX_W-1:0]    mix_num_ff [NUM_CHAN];
   point_type           res_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic                rsp_tvalid_ff;
   point_type           rsp_point_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                req_accept;
   logic                req_cmd;
   logic                req_first;
   point_type           req_point;
   logic [IDX_W-1:0]    req_index;
   logic [CNT_W-1:0]    load_base;
   logic                load_ok;
   logic                mem_wr_en;
   logic                mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   logic [AW-1:0]       hi_addr;
   point_type           mem_rd_data;
   logic [RAMP_W-1:0]   d_val;
   logic [AW-1:0]       count_m1;
   logic [NUM_W-1:0]    num_in;
   logic                pos_start;
   logic                pos_done;
   logic [NUM_W-1:0]    pos_quo;
   logic [RAMP_W-1:0]   pos_rem;
   logic                mix_start;
   logic [NUM_CHAN-1:0] mix_done;
   logic [MIX_W-1:0]    mix_quo [NUM_CHAN];
   logic [RAMP_W-1:0]   mix_rem [NUM_CHAN];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_cmd    = req_tuser[0];
   assign req_first  = req_tuser[1];
   assign req_point  = point_type'(req_tdata[RSP_DATA_W-1:0]);
   assign req_index  = req_tdata[RSP_DATA_W +: IDX_W];
   assign csr_ready  = 1'b1;

   assign load_base = req_first ? '0 : count_ff;
   assign load_ok   = load_base < CNT_W'(MAX_POINTS);
   assign mem_wr_en = req_accept && (req_cmd == CMD_LOAD) && load_ok;

   assign d_val    = ramp_size_ff - RAMP_W'(1);
   assign count_m1 = AW'(count_ff - CNT_W'(1));
   assign num_in   = NUM_W'(count_m1) * NUM_W'(req_index);

   assign hi_addr     = (rem_ff != '0) ? lo_ff + AW'(1) : lo_ff;
   assign mem_rd_en   = (state_ff == ST_RD_LO) || (state_ff == ST_RD_HI);
   assign mem_rd_addr = (state_ff == ST_RD_LO) ? lo_ff : hi_addr;

   assign pos_start = (state_ff == ST_POS_START) && (d_val != '0);
   assign mix_start = (state_ff == ST_MIX_START);

   grlr_point_mem #(
      .DEPTH (MAX_POINTS)
   ) u_point_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (load_base[AW-1:0]),
      .wr_data (req_point),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   grlr_div #(
      .W (NUM_W)
   ) u_pos_div (
      .clock     (clock),
      .reset     (reset),
      .start     (pos_start),
      .dividend  (num_ff),
      .divisor   (d_val),
      .done      (pos_done),
      .quotient  (pos_quo),
      .remainder (pos_rem)
   );

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_mix
      grlr_div #(
         .W (MIX_W)
      ) u_mix_div (
         .clock     (clock),
         .reset     (reset),
         .start     (mix_start),
         .dividend  (mix_num_ff[c]),
         .divisor   (d_val),
         .done      (mix_done[c]),
         .quotient  (mix_quo[c]),
         .remainder (mix_rem[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ramp_size_ff  <= RAMP_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            ramp_size_ff <= csr_data;
         end
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_cmd == CMD_LOAD) begin
                     if (load_ok) begin
                        count_ff <= load_base + CNT_W'(1);
                     end
                  end else begin
                     num_ff <= num_in;
                     res_ff <= '0;
                     if (count_ff == '0) begin
                        res_status_ff <= STATUS_EMPTY;
                        state_ff      <= ST_OUT;
                     end else if ({1'b0, req_index} >= ramp_size_ff) begin
                        res_status_ff <= STATUS_RANGE;
                        state_ff      <= ST_OUT;
                     end else begin
                        res_status_ff <= STATUS_OK;
                        state_ff      <= ST_POS_START;
                     end
                  end
               end
            end
            ST_POS_START: begin
               if (d_val == '0) begin
                  lo_ff    <= '0;
                  rem_ff   <= '0;
                  state_ff <= ST_RD_LO;
               end else begin
                  state_ff <= ST_POS_WAIT;
               end
            end
            ST_POS_WAIT: begin
               if (pos_done) begin
                  lo_ff    <= pos_quo[AW-1:0];
                  rem_ff   <= pos_rem;
                  state_ff <= ST_RD_LO;
               end
            end
            ST_RD_LO: begin
               state_ff <= ST_RD_HI;
            end
            ST_RD_HI: begin
               v1_ff    <= mem_rd_data;
               state_ff <= ST_MIX_MUL;
            end
            ST_MIX_MUL: begin
               for (int c = 0; c < NUM_CHAN; c++) begin
                  mix_num_ff[c] <= MIX_W'(v1_ff[c] * (d_val - rem_ff))
                                 + MIX_W'(mem_rd_data[c] * rem_ff);
               end
               if (rem_ff == '0) begin
                  res_ff   <= v1_ff;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_MIX_START;
               end
            end
            ST_MIX_START: begin
               state_ff <= ST_MIX_WAIT;
            end
            ST_MIX_WAIT: begin
               if (mix_done[0]) begin
                  for (int c = 0; c < NUM_CHAN; c++) begin
                     res_ff[c] <= mix_quo[c][CHAN_W-1:0];
                  end
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_point_ff  <= res_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_point_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count exceeds the store depth");

   a_load_count : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_cmd == CMD_LOAD)) |=> (count_ff != '0))
      else $error("point count is zero after a load");

   a_empty_status : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_cmd == CMD_QUERY) && (count_ff == '0))
      |=> ((state_ff == ST_OUT) && (res_status_ff == STATUS_EMPTY)))
      else $error("query on an empty curve did not report empty");

   a_pos_done : assert property (@(posedge clock) disable iff (reset)
      pos_done |-> (state_ff == ST_POS_WAIT))
      else $error("position divider finished outside its wait state");

   a_mix_done : assert property (@(posedge clock) disable iff (reset)
      (mix_done != '0) |-> ((mix_done == '1) && (state_ff == ST_MIX_WAIT)))
      else $error("blend dividers finished out of step");

endmodule
